@@ sv/remote_motor_ramp_controller_assert.svh @@
// Assertion macros for the remote motor ramp controller.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef REMOTE_MOTOR_RAMP_CONTROLLER_ASSERT_SVH
`define REMOTE_MOTOR_RAMP_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RMRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rmrc_pkg.sv @@
// Shared types, register indexes, phase codes and duty helpers for the
// remote motor ramp controller. No dependencies.
`timescale 1ns / 1ps

package rmrc_pkg;

  // Width of the internal speed and duty registers.
  localparam int unsigned DUTY_BITS = 8;
  // Common width for comparing the duty against 8-bit register values.
  localparam int unsigned CMP_W = (DUTY_BITS > 8) ? DUTY_BITS : 8;

  localparam int unsigned TIMER_W = 10;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_CODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_CODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_DUTY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY     = 3'd6;

  // Sequencer phase codes.
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_SETTLE    = 2'd1;
  localparam logic [1:0] PH_RAMP_UP   = 2'd2;
  localparam logic [1:0] PH_RAMP_DOWN = 2'd3;

  typedef struct packed {
    logic        code_valid;
    logic [31:0] rx_code;
    logic        close_limit_clear;
    logic        open_limit_clear;
  } in_t;

  typedef struct packed {
    logic       relay_close_on;
    logic       relay_open_on;
    logic [7:0] pwm_duty;
    logic       close_active;
    logic       open_active;
    logic [1:0] phase;
  } out_t;

  typedef struct packed {
    logic [31:0]        open_code;
    logic [31:0]        close_code;
    logic [TIMER_W-1:0] hold_ms;
    logic [TIMER_W-1:0] settle_ms;
    logic [7:0]         ramp_step_ms;
    logic [7:0]         start_duty;
    logic [7:0]         max_duty;
  } cfg_t;

  typedef struct packed {
    logic                 close_run;
    logic                 open_run;
    logic [TIMER_W-1:0]   hold_age;
    logic [1:0]           seq_phase;
    logic [TIMER_W-1:0]   phase_timer;
    logic [DUTY_BITS-1:0] speed;
    logic [DUTY_BITS-1:0] duty_out;
    logic                 relay_close;
    logic                 relay_open;
  } state_t;

  // Byte register value brought to the duty width (masked or extended).
  function automatic logic [DUTY_BITS-1:0] duty_from_byte(logic [7:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return w[DUTY_BITS-1:0];
  endfunction

  function automatic logic [CMP_W-1:0] cmp_duty(logic [DUTY_BITS-1:0] v);
    return CMP_W'(v);
  endfunction

  function automatic logic [CMP_W-1:0] cmp_byte(logic [7:0] v);
    return CMP_W'(v);
  endfunction

endpackage

@@ sv/rmrc_cfg_regs.sv @@
// Configuration register file of the remote motor ramp controller.
// Depends on rmrc_pkg for the register indexes and the cfg_t layout.
`timescale 1ns / 1ps

module rmrc_cfg_regs import rmrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; an index past the list changes nothing.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OPEN_CODE:    cfg_d.open_code    = cfg_wdata_i;
        REG_CLOSE_CODE:   cfg_d.close_code   = cfg_wdata_i;
        REG_HOLD_MS:      cfg_d.hold_ms      = cfg_wdata_i[TIMER_W-1:0];
        REG_SETTLE_MS:    cfg_d.settle_ms    = cfg_wdata_i[TIMER_W-1:0];
        REG_RAMP_STEP_MS: cfg_d.ramp_step_ms = cfg_wdata_i[7:0];
        REG_START_DUTY:   cfg_d.start_duty   = cfg_wdata_i[7:0];
        REG_MAX_DUTY:     cfg_d.max_duty     = cfg_wdata_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_code    <= 32'd6969512;
      cfg_q.close_code   <= 32'd6969508;
      cfg_q.hold_ms      <= TIMER_W'(300);
      cfg_q.settle_ms    <= TIMER_W'(100);
      cfg_q.ramp_step_ms <= 8'd5;
      cfg_q.start_duty   <= 8'd150;
      cfg_q.max_duty     <= 8'd255;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/rmrc_step.sv @@
// Next-state and result logic for one millisecond tick item.
// Depends on rmrc_pkg for the item, state and configuration types.
`timescale 1ns / 1ps

module rmrc_step import rmrc_pkg::*; (
  input  cfg_t   cfg_i,
  input  state_t state_i,
  input  in_t    item_i,
  output state_t state_o,
  output out_t   result_o
);

  logic               close_acc;
  logic               open_acc;
  logic               running;
  logic [TIMER_W-1:0] hold_age;
  logic [TIMER_W-1:0] timer;
  logic               close_run;
  logic               open_run;
  logic               ramp_due;
  logic [CMP_W-1:0]   speed_w;
  state_t             st;

  // Saturating tick counters, then the code check and the hold timeout.
  always_comb begin
    hold_age  = (state_i.hold_age < TIMER_MAX) ? state_i.hold_age + 1'b1 : TIMER_MAX;
    timer     = (state_i.phase_timer < TIMER_MAX) ? state_i.phase_timer + 1'b1 : TIMER_MAX;
    close_acc = item_i.code_valid && (item_i.rx_code == cfg_i.close_code)
                && item_i.close_limit_clear;
    open_acc  = item_i.code_valid && !close_acc && (item_i.rx_code == cfg_i.open_code)
                && item_i.open_limit_clear;
    if (close_acc || open_acc) begin
      hold_age = '0;
    end
    close_run = state_i.close_run || close_acc;
    open_run  = state_i.open_run || open_acc;
    if ((close_run || open_run) && (hold_age >= cfg_i.hold_ms)) begin
      close_run = 1'b0;
      open_run  = 1'b0;
    end
    running  = close_run || open_run;
    ramp_due = timer >= TIMER_W'(cfg_i.ramp_step_ms);
  end

  // Four-phase sequencer.
  always_comb begin
    st             = state_i;
    st.close_run   = close_run;
    st.open_run    = open_run;
    st.hold_age    = hold_age;
    st.phase_timer = timer;
    speed_w        = '0;
    unique case (state_i.seq_phase)
      PH_IDLE: begin
        if (running) begin
          // Open wins when both flags are set.
          if (close_run) begin
            st.relay_close = 1'b1;
            st.relay_open  = 1'b0;
          end
          if (open_run) begin
            st.relay_close = 1'b0;
            st.relay_open  = 1'b1;
          end
          st.phase_timer = '0;
          st.seq_phase   = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (timer >= cfg_i.settle_ms) begin
          st.seq_phase   = PH_RAMP_UP;
          st.speed       = duty_from_byte(cfg_i.start_duty);
          st.phase_timer = '0;
        end
      end
      PH_RAMP_UP: begin
        if (ramp_due) begin
          st.phase_timer = '0;
          if (running && (cmp_duty(state_i.speed) < cmp_byte(cfg_i.max_duty))
              && (state_i.speed != '1)) begin
            st.speed    = state_i.speed + 1'b1;
            st.duty_out = state_i.speed + 1'b1;
          end else begin
            st.seq_phase = PH_RAMP_DOWN;
          end
        end
      end
      PH_RAMP_DOWN: begin
        if (ramp_due) begin
          st.phase_timer = '0;
          if (!running && (state_i.speed != '0)) begin
            st.speed    = state_i.speed - 1'b1;
            st.duty_out = state_i.speed - 1'b1;
          end
          // Below the start duty the output stops and the sequencer idles.
          if (cmp_duty(st.speed) < cmp_byte(cfg_i.start_duty)) begin
            st.duty_out  = '0;
            st.seq_phase = PH_IDLE;
          end
        end
      end
      default: st = state_i;
    endcase
    speed_w = cmp_duty(st.duty_out);
  end

  assign state_o = st;

  assign result_o.relay_close_on = st.relay_close;
  assign result_o.relay_open_on  = st.relay_open;
  assign result_o.pwm_duty       = speed_w[7:0];
  assign result_o.close_active   = st.close_run;
  assign result_o.open_active    = st.open_run;
  assign result_o.phase          = st.seq_phase;

endmodule

@@ sv/remote_motor_ramp_controller.sv @@
// Top level of the remote motor ramp controller: input register, tick logic,
// state and result register. Depends on rmrc_pkg, rmrc_cfg_regs, rmrc_step.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------
//   in      | input     | in_valid_i / in_stall_o   | in_item_i (in_t)
//   out     | output    | out_valid_o / out_stall_i | out_item_o (out_t)
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item per clock cycle sustained while the output is not stalled; an item goes
// from the input register through the combinational tick logic into the result
// register, from which its result leaves. Reset clears the run flags, timers,
// duty and relays and loads the register defaults. A stalled output holds its
// result while the input register still takes one more item.
`timescale 1ns / 1ps
`include "remote_motor_ramp_controller_assert.svh"

module remote_motor_ramp_controller import rmrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t   cfg;
  state_t state_q, state_d;
  out_t   result_d;
  logic   s1_valid_q;
  in_t    s1_item_q;
  logic   out_valid_q;
  out_t   out_item_q;
  logic   s1_adv;
  logic   in_acc;

  rmrc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rmrc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // The held item moves on whenever the result register is free or draining.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
  end

  // Controller state advances once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks on the pipeline and the sequencer.
  `RMRC_ASSERT_IMP(a_stall_needs_item, in_stall_o, s1_valid_q && out_valid_q && out_stall_i,
    "input stalled without a blocked item")
  `RMRC_ASSERT_NXT(a_state_holds, !s1_adv, $stable(state_q),
    "controller state changed without an item")
  `RMRC_ASSERT_IMP(a_relays_exclusive, 1'b1, !(state_q.relay_close && state_q.relay_open),
    "both direction relays latched")
  `RMRC_ASSERT_IMP(a_ramp_from_settle,
    (state_q.seq_phase == PH_RAMP_UP) && ($past(state_q.seq_phase) != PH_RAMP_UP),
    $past(state_q.seq_phase) == PH_SETTLE, "ramp up entered from a phase other than settle")

endmodule

@@ tb/ramp_tick_checker.sv @@
// Checker for the remote motor ramp controller: follows register writes, predicts
// one result per accepted tick item and compares it with what leaves the block.
// Depends on rmrc_pkg for the item, result and register types and codes.
`timescale 1ns / 1ps

module ramp_tick_checker import rmrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_t                   in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_t                  out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o,
  output logic [3:0]            phases_seen_o
);

  // Register values that the block loads at reset.
  localparam cfg_t RESET_SETTINGS = '{
    open_code:    32'd6969512,
    close_code:   32'd6969508,
    hold_ms:      TIMER_W'(300),
    settle_ms:    TIMER_W'(100),
    ramp_step_ms: 8'd5,
    start_duty:   8'd150,
    max_duty:     8'd255
  };
  localparam int unsigned REPORT_LIMIT = 10;

  cfg_t   settings;
  state_t motor;
  out_t   tick_expect[$];

  // Advances the controller by one tick and returns the result it should show.
  function automatic out_t ramp_tick(input in_t t);
    logic running;
    out_t r;
    motor.hold_age = (motor.hold_age == TIMER_MAX) ? TIMER_MAX : motor.hold_age + 1'b1;
    motor.phase_timer = (motor.phase_timer == TIMER_MAX) ? TIMER_MAX :
                        motor.phase_timer + 1'b1;

    // Close is tried first; open only counts when close was not taken.
    if (t.code_valid) begin
      if (t.rx_code == settings.close_code && t.close_limit_clear) begin
        motor.hold_age  = '0;
        motor.close_run = 1'b1;
      end else if (t.rx_code == settings.open_code && t.open_limit_clear) begin
        motor.hold_age = '0;
        motor.open_run = 1'b1;
      end
    end

    // Hold timeout drops both run flags.
    if ((motor.close_run || motor.open_run) && motor.hold_age >= settings.hold_ms) begin
      motor.close_run = 1'b0;
      motor.open_run  = 1'b0;
    end
    running = motor.close_run || motor.open_run;

    // Relay latch, settle wait, ramp up, ramp down.
    case (motor.seq_phase)
      PH_IDLE: begin
        if (running) begin
          if (motor.close_run) begin
            motor.relay_close = 1'b1;
            motor.relay_open  = 1'b0;
          end
          if (motor.open_run) begin
            motor.relay_close = 1'b0;
            motor.relay_open  = 1'b1;
          end
          motor.phase_timer = '0;
          motor.seq_phase   = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (motor.phase_timer >= settings.settle_ms) begin
          motor.seq_phase   = PH_RAMP_UP;
          motor.speed       = DUTY_BITS'(settings.start_duty);
          motor.phase_timer = '0;
        end
      end
      PH_RAMP_UP: begin
        if (motor.phase_timer >= settings.ramp_step_ms) begin
          motor.phase_timer = '0;
          if (running && motor.speed < settings.max_duty && motor.speed != '1) begin
            motor.speed    = motor.speed + 1'b1;
            motor.duty_out = motor.speed;
          end else begin
            motor.seq_phase = PH_RAMP_DOWN;
          end
        end
      end
      default: begin
        if (motor.phase_timer >= settings.ramp_step_ms) begin
          motor.phase_timer = '0;
          // The speed holds while a run flag is still set.
          if (!running && motor.speed != '0) begin
            motor.speed    = motor.speed - 1'b1;
            motor.duty_out = motor.speed;
          end
          if (motor.speed < settings.start_duty) begin
            motor.duty_out  = '0;
            motor.seq_phase = PH_IDLE;
          end
        end
      end
    endcase

    r.relay_close_on = motor.relay_close;
    r.relay_open_on  = motor.relay_open;
    r.pwm_duty       = 8'(motor.duty_out);
    r.close_active   = motor.close_run;
    r.open_active    = motor.open_run;
    r.phase          = motor.seq_phase;
    return r;
  endfunction

  // Follow the channels at every edge and compare each result that leaves.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    logic [5:0] bad;
    if (!rst_ni) begin
      settings = RESET_SETTINGS;
      motor = '0;
      tick_expect.delete();
      mismatch_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      phases_seen_o = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OPEN_CODE:    settings.open_code    = cfg_wdata_i;
          REG_CLOSE_CODE:   settings.close_code   = cfg_wdata_i;
          REG_HOLD_MS:      settings.hold_ms      = cfg_wdata_i[TIMER_W-1:0];
          REG_SETTLE_MS:    settings.settle_ms    = cfg_wdata_i[TIMER_W-1:0];
          REG_RAMP_STEP_MS: settings.ramp_step_ms = cfg_wdata_i[7:0];
          REG_START_DUTY:   settings.start_duty   = cfg_wdata_i[7:0];
          REG_MAX_DUTY:     settings.max_duty     = cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        tick_expect.push_back(ramp_tick(in_item_i));
      end

      if (out_valid_i && !out_stall_i) begin
        if (tick_expect.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= REPORT_LIMIT) begin
            $display("tb: unexpected result item %p with no prediction waiting", out_item_i);
          end
        end else begin
          want = tick_expect.pop_front();
          bad = {want.relay_close_on != out_item_i.relay_close_on,
                 want.relay_open_on  != out_item_i.relay_open_on,
                 want.pwm_duty       != out_item_i.pwm_duty,
                 want.close_active   != out_item_i.close_active,
                 want.open_active    != out_item_i.open_active,
                 want.phase          != out_item_i.phase};
          if (bad != '0) begin
            mismatch_count_o++;
            if (mismatch_count_o <= REPORT_LIMIT) begin
              $display("tb: result %0d wrong (fields %b): expected rc=%0b ro=%0b duty=%0d",
                       checked_o, bad,
                       want.relay_close_on, want.relay_open_on, want.pwm_duty);
              $display("tb:   expected ca=%0b oa=%0b ph=%0d",
                       want.close_active, want.open_active, want.phase);
              $display("tb:   got rc=%0b ro=%0b duty=%0d ca=%0b oa=%0b ph=%0d",
                       out_item_i.relay_close_on, out_item_i.relay_open_on,
                       out_item_i.pwm_duty, out_item_i.close_active,
                       out_item_i.open_active, out_item_i.phase);
            end
          end
          phases_seen_o[want.phase] = 1'b1;
          checked_o++;
        end
      end
      pending_o = tick_expect.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the remote motor ramp controller: clock, reset, tick and
// register stimulus, receiver stalls and the verdict. Depends on rmrc_pkg,
// the controller RTL and ramp_tick_checker.
`timescale 1ns / 1ps

module tb import rmrc_pkg::*;;

  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_TICKS   = 75;
  localparam int unsigned LONG_HOLD     = 60;
  localparam int unsigned DRAIN_TAIL    = 6;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam logic [31:0] DEF_OPEN_CODE  = 32'd6969512;
  localparam logic [31:0] DEF_CLOSE_CODE = 32'd6969508;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned tick_pending;
  int unsigned ticks_checked;
  logic [3:0]  phases_seen;
  int unsigned ticks_sent;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_req;

  remote_motor_ramp_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  ramp_tick_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_o        (tick_pending),
    .checked_o        (ticks_checked),
    .phases_seen_o    (phases_seen)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a run that outlives the limit has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // Receiver stalls: random bursts, one long hold on request, none when quiet.
  initial begin
    int burst;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_t make_tick(input logic v, input logic [31:0] code,
                                    input logic cc, input logic oc);
    in_t t;
    t.code_valid        = v;
    t.rx_code           = code;
    t.close_limit_clear = cc;
    t.open_limit_clear  = oc;
    return t;
  endfunction

  // Offers one tick item, sometimes after an idle burst, and waits until taken.
  task automatic offer_tick(input in_t t);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tick_pending != 0);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic post_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  // Writes every register; only called while nothing is in flight.
  task automatic write_settings(input cfg_t s);
    post_reg(REG_OPEN_CODE, s.open_code);
    post_reg(REG_CLOSE_CODE, s.close_code);
    post_reg(REG_HOLD_MS, CFG_DATA_W'(s.hold_ms));
    post_reg(REG_SETTLE_MS, CFG_DATA_W'(s.settle_ms));
    post_reg(REG_RAMP_STEP_MS, CFG_DATA_W'(s.ramp_step_ms));
    post_reg(REG_START_DUTY, CFG_DATA_W'(s.start_duty));
    post_reg(REG_MAX_DUTY, CFG_DATA_W'(s.max_duty));
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_t setting;
    in_t  t;
    bit   go_open;
    int   press;
    int   rest;
    int   phase_count;

    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    ticks_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: blocked end stops, a miss, then both codes taken.
    offer_tick(make_tick(1'b0, '1, 1'b0, 1'b0));
    offer_tick(make_tick(1'b1, DEF_CLOSE_CODE, 1'b0, 1'b1));
    offer_tick(make_tick(1'b1, DEF_OPEN_CODE, 1'b1, 1'b0));
    offer_tick(make_tick(1'b1, '0, 1'b1, 1'b1));
    offer_tick(make_tick(1'b1, DEF_CLOSE_CODE, 1'b1, 1'b1));
    offer_tick(make_tick(1'b1, DEF_OPEN_CODE, 1'b1, 1'b1));
    drain_results();

    // Fast setting: ramp to the top, a fresh code as the ramp turns down, then a stop and a restart.
    setting = '{open_code: '1, close_code: '0, hold_ms: TIMER_W'(3), settle_ms: TIMER_W'(1),
                ramp_step_ms: 8'd0, start_duty: 8'd250, max_duty: 8'd252};
    write_settings(setting);
    repeat (4) offer_tick(make_tick(1'b1, '1, 1'b1, 1'b1));
    offer_tick(make_tick(1'b1, '0, 1'b1, 1'b1));
    repeat (5) offer_tick(make_tick(1'b0, '0, 1'b1, 1'b1));
    offer_tick(make_tick(1'b1, '0, 1'b1, 1'b1));
    offer_tick(make_tick(1'b1, '1, 1'b1, 1'b1));
    offer_tick(make_tick(1'b0, '1, 1'b0, 1'b0));
    drain_results();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      setting.open_code    = $urandom;
      setting.close_code   = $urandom;
      setting.hold_ms      = TIMER_W'($urandom_range(0, 40));
      setting.settle_ms    = TIMER_W'($urandom_range(0, 6));
      setting.ramp_step_ms = 8'($urandom_range(0, 3));
      setting.start_duty   = 8'($urandom_range(0, 255));
      setting.max_duty     = setting.start_duty + 8'($urandom_range(0, 12));
      case (ph)
        // Slowest timers and the top duty.
        0: begin
          setting.open_code    = '1;
          setting.close_code   = '0;
          setting.hold_ms      = '1;
          setting.settle_ms    = '1;
          setting.ramp_step_ms = 8'd255;
          setting.start_duty   = 8'd255;
          setting.max_duty     = 8'd255;
        end
        // Zero hold time: codes never keep a run flag.
        1: begin
          setting.hold_ms      = '0;
          setting.settle_ms    = '0;
          setting.ramp_step_ms = 8'd0;
          setting.start_duty   = 8'd0;
          setting.max_duty     = 8'd0;
        end
        // Both codes equal, and a zero start duty that parks in ramp down.
        2: begin
          setting.close_code   = setting.open_code;
          setting.hold_ms      = TIMER_W'(6);
          setting.ramp_step_ms = 8'd1;
          setting.start_duty   = 8'd0;
          setting.max_duty     = 8'd4;
        end
        // Ramp up that ends at the widest duty value.
        3: begin
          setting.hold_ms      = TIMER_W'(300);
          setting.ramp_step_ms = 8'd0;
          setting.start_duty   = 8'd200;
          setting.max_duty     = 8'd255;
        end
        // Maximum below the start duty.
        4: begin
          setting.start_duty = 8'd40;
          setting.max_duty   = 8'd30;
        end
        default: ;
      endcase
      if (ph == 6) hold_req = 1'b1;
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      write_settings(setting);

      // Presses of one button with random content, then a release with noise.
      phase_count = 0;
      while (phase_count < PHASE_TICKS) begin
        go_open = 1'($urandom_range(0, 1));
        press = $urandom_range(1, 40);
        for (int k = 0; k < press; k++) begin
          t = make_tick($urandom_range(0, 3) != 0,
                        go_open ? setting.open_code : setting.close_code,
                        $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
          if ($urandom_range(0, 11) == 0) begin
            t.rx_code = go_open ? setting.close_code : setting.open_code;
          end else if ($urandom_range(0, 11) == 0) begin
            t.rx_code = $urandom;
          end
          offer_tick(t);
        end
        rest = $urandom_range(0, 50);
        for (int k = 0; k < rest; k++) begin
          offer_tick(make_tick($urandom_range(0, 7) == 0, $urandom,
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        phase_count += press + rest;
      end
      drain_results();
    end

    $display("tb: %0d tick items under %0d register settings, %0d results checked",
             ticks_sent, NUM_PHASES + 2, ticks_checked);
    $display("tb: sequencer phases reached (ramp down, ramp up, settle, idle) = %b",
             phases_seen);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/rmrc_pkg.sv
sv/rmrc_cfg_regs.sv
sv/rmrc_step.sv
sv/remote_motor_ramp_controller.sv
tb/ramp_tick_checker.sv
tb/tb.sv
